// File: design/ssc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths and stage payload types of the sphere contact pipeline.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int RAD_W   = 31;
  localparam int NRM_W   = FRAC_W + 2;
  localparam int PEN_W   = 32;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = 32;
  localparam int REM_W   = 35;
  localparam int QUO_W   = FRAC_W + 1;
  localparam int NUM_W   = 49;
  localparam int K2_W    = 34;
  localparam int PROD_W  = NRM_W + K2_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] ocx;
    logic signed [COORD_W-1:0] ocy;
    logic signed [COORD_W-1:0] ocz;
    logic signed [COORD_W-1:0] pcx;
    logic signed [COORD_W-1:0] pcy;
    logic signed [COORD_W-1:0] pcz;
    logic [RAD_W-1:0]          pr;
    logic                      sph;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W:0]   dx;
    logic signed [COORD_W:0]   dy;
    logic signed [COORD_W:0]   dz;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] oz;
    logic [PEN_W-1:0]          rsum;
    logic                      hit;
    logic                      zero;
  } geo_t;

  typedef struct packed {
    geo_t            g;
    logic [SQ_W-1:0] s;
  } front_t;

  typedef struct packed {
    geo_t              g;
    logic [ROOT_W-1:0] dlen;
  } root_t;

  typedef struct packed {
    geo_t                    g;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic [PEN_W-1:0]        pen;
    logic signed [K2_W-1:0]  k2;
  } nrm_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic signed [NRM_W-1:0]   nx;
    logic signed [NRM_W-1:0]   ny;
    logic signed [NRM_W-1:0]   nz;
    logic [PEN_W-1:0]          pen;
  } res_t;

endpackage
`default_nettype wire

// File: design/ssc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_front
// Center differences, squares and the overlap test against the radius sum.
// ----------------------------------------------------------------------------
module ssc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ssc_pkg::RAD_W-1:0]     own_radius,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ssc_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ssc_pkg::front_t               out_data
);
  import ssc_pkg::*;

  logic [2:0] v;
  logic [3:0] rdy;

  geo_t                a_geo;
  logic [COORD_W-1:0]  a_mx, a_my, a_mz;
  geo_t                b_geo;
  logic [SQ_W-1:0]     b_sx, b_sy, b_sz, b_rsq;
  front_t              c_q;
  geo_t                c_geo_next;

  logic signed [COORD_W:0] dx, dy, dz;
  logic [PEN_W-1:0]        rsum;
  logic [SQ_W+1:0]         ssum;

  assign rdy[3] = out_ready;
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];
  assign in_ready = rdy[0];

  assign dx   = {in_data.pcx[COORD_W-1], in_data.pcx} - {in_data.ocx[COORD_W-1], in_data.ocx};
  assign dy   = {in_data.pcy[COORD_W-1], in_data.pcy} - {in_data.ocy[COORD_W-1], in_data.ocy};
  assign dz   = {in_data.pcz[COORD_W-1], in_data.pcz} - {in_data.ocz[COORD_W-1], in_data.ocz};
  assign rsum = {1'b0, own_radius} + {1'b0, in_data.pr};
  assign ssum = {2'b00, b_sx} + {2'b00, b_sy} + {2'b00, b_sz};

  always_comb begin
    c_geo_next      = b_geo;
    c_geo_next.hit  = b_geo.hit && (ssum < {2'b00, b_rsq});
    c_geo_next.zero = (ssum == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_geo.dx   <= dx;
      a_geo.dy   <= dy;
      a_geo.dz   <= dz;
      a_geo.ox   <= in_data.ocx;
      a_geo.oy   <= in_data.ocy;
      a_geo.oz   <= in_data.ocz;
      a_geo.rsum <= rsum;
      a_geo.hit  <= in_data.sph && (rsum != '0);
      a_geo.zero <= 1'b0;
      a_mx       <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      a_my       <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      a_mz       <= dz[COORD_W] ? COORD_W'(-dz) : dz[COORD_W-1:0];
    end
    if (rdy[1]) begin
      b_geo <= a_geo;
      b_sx  <= a_mx * a_mx;
      b_sy  <= a_my * a_my;
      b_sz  <= a_mz * a_mz;
      b_rsq <= a_geo.rsum * a_geo.rsum;
    end
    if (rdy[2]) begin
      c_q.g <= c_geo_next;
      c_q.s <= ssum[SQ_W-1:0];
    end
  end

  assign out_valid = v[2];
  assign out_data  = c_q;

endmodule
`default_nettype wire

// File: design/ssc_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ssc_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssc_pkg::front_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ssc_pkg::root_t     out_data
);
  import ssc_pkg::*;

  logic [ROOT_W-1:0] v;
  logic [ROOT_W:0]   rdy;
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [SQ_W-1:0]   val_q  [ROOT_W];
  geo_t              geo_q  [ROOT_W];

  assign rdy[ROOT_W] = out_ready;
  assign in_ready    = rdy[0];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [ROOT_W-1:0] root_i;
    logic [REM_W-1:0]  rem_i;
    logic [SQ_W-1:0]   val_i;
    geo_t              geo_i;
    logic              vin;
    logic [REM_W-1:0]  rem_n;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign root_i = '0;
      assign rem_i  = '0;
      assign val_i  = in_data.s;
      assign geo_i  = in_data.g;
      assign vin    = in_valid;
    end else begin : g_next
      assign root_i = root_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign val_i  = val_q[k-1];
      assign geo_i  = geo_q[k-1];
      assign vin    = v[k-1];
    end

    assign rdy[k] = !v[k] || rdy[k+1];
    assign rem_n  = {rem_i[REM_W-3:0], val_i[SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_i, 2'b01};
    assign ge     = rem_n >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (rdy[k]) begin
        v[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem_q[k]  <= ge ? rem_n - trial : rem_n;
        root_q[k] <= {root_i[ROOT_W-2:0], ge};
        val_q[k]  <= {val_i[SQ_W-3:0], 2'b00};
        geo_q[k]  <= geo_i;
      end
    end
  end

  assign out_valid     = v[ROOT_W-1];
  assign out_data.g    = geo_q[ROOT_W-1];
  assign out_data.dlen = root_q[ROOT_W-1];

endmodule
`default_nettype wire

// File: design/ssc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_div
// Three-lane pipelined divider for the rounded unit normal, plus penetration.
// ----------------------------------------------------------------------------
module ssc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ssc_pkg::RAD_W-1:0] own_radius,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ssc_pkg::root_t            in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ssc_pkg::nrm_t             out_data
);
  import ssc_pkg::*;

  localparam int NST = QUO_W + 1;

  logic [NST:0]        v;
  logic [NST+1:0]      rdy;
  logic [ROOT_W-1:0]   rem_q [NST][3];
  logic [QUO_W-1:0]    quo_q [NST][3];
  logic [NUM_W-1:0]    num_q [NST][3];
  root_t               meta_q [NST];
  nrm_t                fin_q;

  logic signed [COORD_W:0] dif [3];
  logic [COORD_W-1:0]      mag [3];
  logic [NUM_W-1:0]        num [3];

  assign rdy[NST+1] = out_ready;
  assign in_ready   = rdy[0];

  for (genvar k = 0; k <= NST; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end

  assign dif[0] = in_data.g.dx;
  assign dif[1] = in_data.g.dy;
  assign dif[2] = in_data.g.dz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = dif[i][COORD_W] ? COORD_W'(-dif[i]) : dif[i][COORD_W-1:0];
      num[i] = {1'b0, mag[i], {FRAC_W{1'b0}}} + NUM_W'(in_data.dlen[ROOT_W-1:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k <= NST; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      meta_q[0] <= in_data;
      for (int i = 0; i < 3; i++) begin
        num_q[0][i] <= num[i];
        rem_q[0][i] <= num[i][NUM_W-1 -: ROOT_W];
        quo_q[0][i] <= '0;
      end
    end
  end

  for (genvar k = 1; k < NST; k++) begin : g_step
    logic [ROOT_W:0] rem_n [3];
    logic [ROOT_W:0] den;
    logic [2:0]      ge;

    assign den = {1'b0, meta_q[k-1].dlen};

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_n[i] = {rem_q[k-1][i], num_q[k-1][i][QUO_W-k]};
        ge[i]    = rem_n[i] >= den;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        meta_q[k] <= meta_q[k-1];
        for (int i = 0; i < 3; i++) begin
          num_q[k][i] <= num_q[k-1][i];
          rem_q[k][i] <= ge[i] ? ROOT_W'(rem_n[i] - den) : rem_n[i][ROOT_W-1:0];
          quo_q[k][i] <= {quo_q[k-1][i][QUO_W-2:0], ge[i]};
        end
      end
    end
  end

  logic signed [NRM_W-1:0] nq [3];
  logic [PEN_W-1:0]        pen;
  root_t                   last;
  logic                    neg [3];

  assign last   = meta_q[NST-1];
  assign neg[0] = last.g.dx[COORD_W];
  assign neg[1] = last.g.dy[COORD_W];
  assign neg[2] = last.g.dz[COORD_W];
  assign pen    = last.g.rsum - last.dlen;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (last.g.zero) begin
        nq[i] = (i == 0) ? NRM_W'(1 << FRAC_W) : '0;
      end else if (neg[i]) begin
        nq[i] = -$signed({1'b0, quo_q[NST-1][i]});
      end else begin
        nq[i] = $signed({1'b0, quo_q[NST-1][i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST]) begin
      fin_q.g   <= last.g;
      fin_q.nx  <= nq[0];
      fin_q.ny  <= nq[1];
      fin_q.nz  <= nq[2];
      fin_q.pen <= pen;
      fin_q.k2  <= $signed({2'b00, own_radius, 1'b0}) - $signed({2'b00, pen});
    end
  end

  assign out_valid = v[NST];
  assign out_data  = fin_q;

endmodule
`default_nettype wire

// File: design/ssc_contact.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_contact
// Contact point along the normal, rounding, saturation and result register.
// ----------------------------------------------------------------------------
module ssc_contact (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ssc_pkg::nrm_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ssc_pkg::res_t   out_data
);
  import ssc_pkg::*;

  localparam int OFF_W = PROD_W - FRAC_W;
  localparam int SUM_W = PROD_W + 2;

  logic [1:0] v;
  logic [2:0] rdy;

  nrm_t                     m_q;
  logic signed [PROD_W-1:0] prod_q [3];
  res_t                     r_q;

  logic signed [COORD_W-1:0] own [3];
  logic [PROD_W-1:0]         pm  [3];
  logic [OFF_W-1:0]          offm [3];
  logic signed [SUM_W-1:0]   sum [3];
  logic signed [COORD_W-1:0] sat [3];

  localparam logic signed [SUM_W-1:0] HI = SUM_W'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] LO = -HI - SUM_W'(1);

  assign rdy[2]   = out_ready;
  assign rdy[1]   = !v[1] || rdy[2];
  assign rdy[0]   = !v[0] || rdy[1];
  assign in_ready = rdy[0];

  assign own[0] = m_q.g.ox;
  assign own[1] = m_q.g.oy;
  assign own[2] = m_q.g.oz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pm[i]   = prod_q[i][PROD_W-1] ? PROD_W'(-prod_q[i]) : prod_q[i];
      offm[i] = OFF_W'((pm[i] + PROD_W'(1 << FRAC_W)) >> (FRAC_W + 1));
      if (prod_q[i][PROD_W-1]) begin
        sum[i] = SUM_W'(own[i]) - $signed({1'b0, offm[i]});
      end else begin
        sum[i] = SUM_W'(own[i]) + $signed({1'b0, offm[i]});
      end
      if (sum[i] > HI) begin
        sat[i] = HI[COORD_W-1:0];
      end else if (sum[i] < LO) begin
        sat[i] = LO[COORD_W-1:0];
      end else begin
        sat[i] = sum[i][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      m_q       <= in_data;
      prod_q[0] <= in_data.nx * in_data.k2;
      prod_q[1] <= in_data.ny * in_data.k2;
      prod_q[2] <= in_data.nz * in_data.k2;
    end
    if (rdy[1]) begin
      if (m_q.g.hit) begin
        r_q.hit <= 1'b1;
        r_q.cx  <= sat[0];
        r_q.cy  <= sat[1];
        r_q.cz  <= sat[2];
        r_q.nx  <= m_q.nx;
        r_q.ny  <= m_q.ny;
        r_q.nz  <= m_q.nz;
        r_q.pen <= m_q.pen;
      end else begin
        r_q <= '0;
      end
    end
  end

  assign out_valid = v[1];
  assign out_data  = r_q;

endmodule
`default_nettype wire

// File: design/sphere_sphere_contact_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_sphere_contact_unit
// Sphere against sphere contact: overlap test, unit normal, penetration and
// saturated contact point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   dir  bits  contents
//  s_*       in   224   own center xyz, peer center xyz, peer radius; tuser: sphere
//  m_*       out  184   contact xyz, normal xyz, penetration; tuser: hit
//  cfg_*     in   31    own radius
//
//  One transfer per cycle in each direction while m_tready stays high; the
//  path runs through the front, square root, divider and normal, and contact stages.
//  Depth is set by the one-bit-per-stage root and quotient pipelines.
//  rst clears all valid bits and sets own radius to 1.0.
//  A stall at m_tready holds full stages and lets bubbles close up.
// ----------------------------------------------------------------------------
module sphere_sphere_contact_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [30:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // own_center_x, own_center_y, own_center_z, peer_center_x, peer_center_y,
  // peer_center_z, peer_radius, zero pad
  input  logic [223:0] s_tdata,
  // peer_is_sphere
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // contact_x, contact_y, contact_z, normal_x, normal_y, normal_z, penetration,
  // zero pad
  output logic [183:0] m_tdata,
  // hit
  output logic         m_tuser
);
  import ssc_pkg::*;

  logic [RAD_W-1:0] own_radius;
  in_t              in_d;
  front_t           f_d;
  root_t            r_d;
  nrm_t             n_d;
  res_t             o_d;
  logic             f_v, f_r, r_v, r_r, n_v, n_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_radius <= RAD_W'(1 << FRAC_W);
    end else if (cfg_we) begin
      own_radius <= cfg_wdata;
    end
  end

  assign in_d.ocx = s_tdata[31:0];
  assign in_d.ocy = s_tdata[63:32];
  assign in_d.ocz = s_tdata[95:64];
  assign in_d.pcx = s_tdata[127:96];
  assign in_d.pcy = s_tdata[159:128];
  assign in_d.pcz = s_tdata[191:160];
  assign in_d.pr  = s_tdata[222:192];
  assign in_d.sph = s_tuser;

  ssc_front u_front (
    .clk, .rst, .own_radius,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(in_d),
    .out_valid(f_v), .out_ready(f_r), .out_data(f_d)
  );

  ssc_sqrt u_sqrt (
    .clk, .rst,
    .in_valid(f_v), .in_ready(f_r), .in_data(f_d),
    .out_valid(r_v), .out_ready(r_r), .out_data(r_d)
  );

  ssc_div u_div (
    .clk, .rst, .own_radius,
    .in_valid(r_v), .in_ready(r_r), .in_data(r_d),
    .out_valid(n_v), .out_ready(n_r), .out_data(n_d)
  );

  ssc_contact u_contact (
    .clk, .rst,
    .in_valid(n_v), .in_ready(n_r), .in_data(n_d),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(o_d)
  );

  assign m_tdata = {2'b00, o_d.pen, o_d.nz, o_d.ny, o_d.nx, o_d.cz, o_d.cy, o_d.cx};
  assign m_tuser = o_d.hit;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss result carries nonzero fields");

  a_hit_pen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[181:150] != '0)
    else $error("hit with zero penetration");

  a_hit_nx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      $signed(m_tdata[113:96]) <= 18'sd65536 && $signed(m_tdata[113:96]) >= -18'sd65536)
    else $error("normal x out of unit range");
`endif

endmodule
`default_nettype wire

// File: dv/sphere_sphere_contact_unit_test.sv
// ----------------------------------------------------------------------------
// sphere_sphere_contact_unit_test
// Streams sphere pairs through the contact unit with random gaps and stalls
// on both sides, and checks every result against a scoreboard that works out
// hit, normal, penetration and contact point for each accepted pair.
// ----------------------------------------------------------------------------
class contact_scoreboard;
  ssc_pkg::res_t expected_q[$];
  logic [30:0]   own_radius;
  int            errors;

  function new();
    own_radius = 31'd65536;
    errors     = 0;
  endfunction

  function longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function void note_pair(logic [223:0] data, logic sphere);
    ssc_pkg::res_t res;
    longint        own_c[3];
    longint        dif[3];
    longint        nrm[3];
    longint        k2;
    longint        off;
    longint        sum;
    logic [63:0]   rsum;
    logic [63:0]   s;
    logic [63:0]   m;
    logic [63:0]   sq;
    logic [63:0]   root;
    logic [63:0]   pen;
    bit            hit;
    res  = '0;
    rsum = 64'(own_radius) + 64'(data[222:192]);
    hit  = sphere && (rsum != 0);
    for (int i = 0; i < 3; i++) begin
      own_c[i] = longint'($signed(data[32*i +: 32]));
      dif[i]   = longint'($signed(data[96 + 32*i +: 32])) - own_c[i];
      if (dif[i] > 64'sh0FFFFFFFF || dif[i] < -64'sh0FFFFFFFF) hit = 0;
    end
    if (hit) begin
      s = 0;
      for (int i = 0; i < 3; i++) begin
        m  = (dif[i] < 0) ? 64'(-dif[i]) : 64'(dif[i]);
        sq = m * m;
        s  = (s > ~64'd0 - sq) ? ~64'd0 : s + sq;
      end
      if (s < rsum * rsum) begin
        root = int_sqrt(s);
        pen  = rsum - root;
        if (s == 0) begin
          nrm[0] = 65536;
          nrm[1] = 0;
          nrm[2] = 0;
        end else begin
          for (int i = 0; i < 3; i++) nrm[i] = round_div(dif[i] * 65536, longint'(root));
        end
        k2      = 2 * longint'(own_radius) - longint'(pen);
        res.hit = 1'b1;
        res.pen = pen[31:0];
        for (int i = 0; i < 3; i++) begin
          off = round_div(nrm[i] * k2, 131072);
          sum = own_c[i] + off;
          if (sum > 64'sh7FFFFFFF) sum = 64'sh7FFFFFFF;
          if (sum < -64'sh80000000) sum = -64'sh80000000;
          case (i)
            0: begin res.cx = sum[31:0]; res.nx = nrm[i][17:0]; end
            1: begin res.cy = sum[31:0]; res.ny = nrm[i][17:0]; end
            default: begin res.cz = sum[31:0]; res.nz = nrm[i][17:0]; end
          endcase
        end
      end
    end
    expected_q.insert(expected_q.size(), res);
  endfunction

  function void check_result(logic [183:0] data, logic hit);
    ssc_pkg::res_t got;
    ssc_pkg::res_t exp_r;
    got.hit = hit;
    got.cx  = data[31:0];
    got.cy  = data[63:32];
    got.cz  = data[95:64];
    got.nx  = data[113:96];
    got.ny  = data[131:114];
    got.nz  = data[149:132];
    got.pen = data[181:150];
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result hit=%0b data=%h", $time, hit, data);
      return;
    end
    exp_r = expected_q.pop_front();
    if (data[183:182] != 2'b00) begin
      errors++;
      $display("%0t: pad expected 0 actual %b", $time, data[183:182]);
    end
    if (got.hit != exp_r.hit) begin
      errors++;
      $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, got.hit);
    end
    if (got.cx != exp_r.cx || got.cy != exp_r.cy || got.cz != exp_r.cz) begin
      errors++;
      $display("%0t: contact expected %0d %0d %0d actual %0d %0d %0d", $time,
               exp_r.cx, exp_r.cy, exp_r.cz, got.cx, got.cy, got.cz);
    end
    if (got.nx != exp_r.nx || got.ny != exp_r.ny || got.nz != exp_r.nz) begin
      errors++;
      $display("%0t: normal expected %0d %0d %0d actual %0d %0d %0d", $time,
               exp_r.nx, exp_r.ny, exp_r.nz, got.nx, got.ny, got.nz);
    end
    if (got.pen != exp_r.pen) begin
      errors++;
      $display("%0t: penetration expected %0d actual %0d", $time, exp_r.pen, got.pen);
    end
  endfunction
endclass

module sphere_sphere_contact_unit_test;
  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [30:0]  cfg_wdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [223:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [183:0] m_tdata;
  logic         m_tuser;

  contact_scoreboard sb;
  bit                calm;
  bit                stall_req;
  int                idle_cycles;

  sphere_sphere_contact_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    sb        = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    m_tready  = 1'b0;
    calm      = 1'b0;
    stall_req = 1'b0;
  end

  task automatic send_pair(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [30:0] pr, logic sphere);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, pr, pz, py, px, oz, oy, ox};
    s_tuser  <= sphere;
    do @(posedge clk); while (!s_tready);
    sb.note_pair({1'b0, pr, pz, py, px, oz, oy, ox}, sphere);
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_radius(logic [30:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.own_radius = value;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic [31:0] o[3];
    logic [31:0] p[3];
    logic [30:0] pr;
    longint      lim;
    int          kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      pr   = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
      lim  = (longint'(sb.own_radius) + longint'(pr)) * 2 / 3 + 1;
      if (lim > 64'sh7FFFFFFF) lim = 64'sh7FFFFFFF;
      for (int i = 0; i < 3; i++) begin
        o[i] = $urandom;
        if (kind < 7) begin
          p[i] = o[i] + 32'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
        end else begin
          p[i] = $urandom;
        end
      end
      if (kind == 9) p = o;
      send_pair(o[0], o[1], o[2], p[0], p[1], p[2], pr, $urandom_range(0, 9) != 0);
    end
  endtask

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 3000) begin
      $display("sphere_sphere_contact_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (stall_req) begin
        m_tready <= 1'b0;
        for (int c = 0; c < 400; c++) @(posedge clk);
        stall_req = 1'b0;
      end
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata, m_tuser);
    end
  end

  initial begin
    logic [30:0] radii[4];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pair(0, 0, 0, 0, 0, 0, 31'd65536, 1'b1);
    send_pair(32'h10000, 0, 0, 32'h10000, 0, 0, 0, 1'b1);
    send_pair(0, 0, 0, 32'h8000, 0, 0, 31'd65536, 1'b0);
    send_pair(0, 0, 0, 32'h8000, 32'h8000, 32'h8000, 31'd65536, 1'b1);
    send_pair(0, 0, 0, 32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000, 31'd65536, 1'b1);
    send_pair(0, 0, 0, 32'h20000, 0, 0, 31'd65536, 1'b1);
    send_pair(0, 0, 0, 32'h1FFFF, 0, 0, 31'd65536, 1'b1);
    send_pair(32'h80000000, 32'h80000000, 32'h80000000,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 1'b1);
    send_pair(32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h80000000, 0,
              31'h7FFFFFFF, 1'b1);
    send_pair(32'h7FFF0000, 0, 0, 32'h7FFFFFFF, 0, 0, 31'h7FFFFFFF, 1'b1);
    send_pair(32'h80010000, 0, 0, 32'h80000000, 0, 0, 31'h7FFFFFFF, 1'b1);
    send_pair(0, 0, 0, 0, 0, 1, 31'd1, 1'b1);
    send_pair(5, 6, 7, 5, 6, 7, 31'h7FFFFFFF, 1'b0);
    drain();

    write_radius(31'h7FFFFFFF);
    send_pair(0, 0, 0, 0, 0, 0, 31'h7FFFFFFF, 1'b1);
    send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFE, 0, 0, 0, 1'b1);
    send_pair(32'h80000000, 32'h80000000, 32'h80000000,
              32'h7FFFFFFF, 32'h80000000, 32'h80000000, 31'h7FFFFFFF, 1'b1);
    send_pair(0, 0, 0, 32'h40000000, 32'hC0000000, 32'h40000000, 0, 1'b1);
    send_random(180);
    drain();

    write_radius(31'd0);
    send_pair(0, 0, 0, 0, 0, 0, 0, 1'b1);
    send_pair(0, 0, 0, 0, 0, 0, 31'd1, 1'b1);
    send_pair(0, 0, 0, 1, 0, 0, 31'd1, 1'b1);
    calm = 1'b1;
    send_random(100);
    calm = 1'b0;
    stall_req = 1'b1;
    send_random(100);
    drain();

    radii[0] = 31'($urandom_range(1, 1 << 18));
    radii[1] = 31'($urandom);
    radii[2] = 31'($urandom_range(1 << 16, 1 << 22));
    radii[3] = 31'd65536;
    for (int ph = 0; ph < 4; ph++) begin
      write_radius(radii[ph]);
      calm = (ph == 2);
      send_random(200);
      drain();
    end

    if (sb.errors == 0) begin
      $display("sphere_sphere_contact_unit verification clean");
    end else begin
      $display("sphere_sphere_contact_unit verification failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/ssc_pkg.sv
design/ssc_front.sv
design/ssc_sqrt.sv
design/ssc_div.sv
design/ssc_contact.sv
design/sphere_sphere_contact_unit.sv
dv/sphere_sphere_contact_unit_test.sv
